>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on aclk and are
// disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_IMPLY_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ole_pkg.sv
`timescale 1ns / 1ps

package ole_pkg;

    // Depth of the entry store; position is 8 bits wide
    localparam int STORE_DEPTH  = 256;
    localparam int CAPACITY_DEF = 256;

    typedef enum logic [2:0] {
        FUNC_APPEND     = 3'd0,
        FUNC_INSERT     = 3'd1,
        FUNC_REMOVE_AT  = 3'd2,
        FUNC_REMOVE_VAL = 3'd3,
        FUNC_FIND       = 3'd4,
        FUNC_READ       = 3'd5,
        FUNC_WRITE      = 3'd6,
        FUNC_CLEAR      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_INDEX = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DISPATCH,
        SEQ_SHIFT_UP,
        SEQ_INS_WRITE,
        SEQ_SHIFT_DOWN,
        SEQ_SEARCH,
        SEQ_READ_WAIT,
        SEQ_RESULT
    } seq_state_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  found_position;
        logic [31:0] read_data;
        logic [8:0]  count;
        logic        empty_res;
    } result_t;

    // IEEE single-precision equality: NaN never matches, +0 == -0
    function automatic logic ieee_equal(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        a_nan     = a[30:0] > 31'h7F80_0000;
        b_nan     = b[30:0] > 31'h7F80_0000;
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        return !a_nan && !b_nan && (both_zero || (a == b));
    endfunction

endpackage

>>> hw/rtl/ole_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/ole_seq.sv
`timescale 1ns / 1ps

// Operation sequencer: owns the element count and walks the entry RAM
module ole_seq #(
    parameter int  CAPACITY = ole_pkg::CAPACITY_DEF,
    localparam int LIMIT    = (CAPACITY < ole_pkg::STORE_DEPTH) ? CAPACITY
                                                                : ole_pkg::STORE_DEPTH,
    localparam int AW       = $clog2(LIMIT)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_func,
    input  logic [7:0]           s_position,
    input  logic [31:0]          s_value,
    // entry RAM
    output logic                 ram_we,
    output logic [AW-1:0]        ram_waddr,
    output logic [31:0]          ram_wdata,
    output logic [AW-1:0]        ram_raddr,
    input  logic [31:0]          ram_rdata,
    // result
    output logic                 res_valid,
    input  logic                 res_ready,
    output ole_pkg::result_t     res
);

    localparam logic [8:0] LIMIT_CNT = 9'(LIMIT);

    ole_pkg::seq_state_t state_reg, state_next;
    ole_pkg::func_t      func_reg, func_next;
    logic [7:0]          pos_reg, pos_next;
    logic [31:0]         value_reg, value_next;
    logic [8:0]          count_reg, count_next;
    logic [8:0]          cursor_reg, cursor_next;
    logic                mv_valid_reg, mv_valid_next;
    logic [AW-1:0]       mv_addr_reg, mv_addr_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [7:0]          cmp_tag_reg, cmp_tag_next;
    ole_pkg::status_t    res_status_reg, res_status_next;
    logic [7:0]          res_found_reg, res_found_next;
    logic [31:0]         res_rdata_reg, res_rdata_next;
    logic [8:0]          pos_ext;

    assign pos_ext = {1'b0, pos_reg};

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ole_pkg::SEQ_IDLE;
            count_reg     <= '0;
            mv_valid_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mv_valid_reg  <= mv_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // Command and working payload
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        cursor_reg     <= cursor_next;
        mv_addr_reg    <= mv_addr_next;
        cmp_tag_reg    <= cmp_tag_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_rdata_reg  <= res_rdata_next;
    end

    // Next state, RAM control and handshakes
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        mv_valid_next   = 1'b0;
        mv_addr_next    = mv_addr_reg;
        cmp_valid_next  = 1'b0;
        cmp_tag_next    = cmp_tag_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_rdata_next  = res_rdata_reg;
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        // a pending entry move owns the write port by default
        ram_we          = mv_valid_reg;
        ram_waddr       = mv_addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = cursor_reg[AW-1:0];

        unique case (state_reg)
            ole_pkg::SEQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next  = ole_pkg::func_t'(s_func);
                    pos_next   = s_position;
                    value_next = s_value;
                    state_next = ole_pkg::SEQ_DISPATCH;
                end
            end

            ole_pkg::SEQ_DISPATCH: begin
                res_status_next = ole_pkg::STATUS_OK;
                res_found_next  = '0;
                res_rdata_next  = '0;
                state_next      = ole_pkg::SEQ_RESULT;
                unique case (func_reg)
                    ole_pkg::FUNC_APPEND: begin
                        if (count_reg >= LIMIT_CNT) begin
                            res_status_next = ole_pkg::STATUS_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = value_reg;
                            count_next = count_reg + 9'd1;
                        end
                    end
                    ole_pkg::FUNC_INSERT: begin
                        if (pos_ext > count_reg) begin
                            res_status_next = ole_pkg::STATUS_BAD_INDEX;
                        end else if (count_reg >= LIMIT_CNT) begin
                            res_status_next = ole_pkg::STATUS_FULL;
                        end else if (pos_ext == count_reg) begin
                            ram_we     = 1'b1;
                            ram_waddr  = pos_reg[AW-1:0];
                            ram_wdata  = value_reg;
                            count_next = count_reg + 9'd1;
                        end else begin
                            cursor_next = count_reg - 9'd1;
                            state_next  = ole_pkg::SEQ_SHIFT_UP;
                        end
                    end
                    ole_pkg::FUNC_REMOVE_AT: begin
                        if (pos_ext >= count_reg) begin
                            res_status_next = ole_pkg::STATUS_BAD_INDEX;
                        end else begin
                            cursor_next = pos_ext + 9'd1;
                            state_next  = ole_pkg::SEQ_SHIFT_DOWN;
                        end
                    end
                    ole_pkg::FUNC_REMOVE_VAL, ole_pkg::FUNC_FIND: begin
                        cursor_next = '0;
                        state_next  = ole_pkg::SEQ_SEARCH;
                    end
                    ole_pkg::FUNC_READ: begin
                        if (pos_ext >= count_reg) begin
                            res_status_next = ole_pkg::STATUS_BAD_INDEX;
                        end else begin
                            ram_raddr  = pos_reg[AW-1:0];
                            state_next = ole_pkg::SEQ_READ_WAIT;
                        end
                    end
                    ole_pkg::FUNC_WRITE: begin
                        if (pos_ext >= count_reg) begin
                            res_status_next = ole_pkg::STATUS_BAD_INDEX;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg[AW-1:0];
                            ram_wdata = value_reg;
                        end
                    end
                    ole_pkg::FUNC_CLEAR: begin
                        count_next = '0;
                    end
                endcase
            end

            // Walk down from the last entry, moving each one up a slot
            ole_pkg::SEQ_SHIFT_UP: begin
                ram_raddr     = cursor_reg[AW-1:0];
                mv_valid_next = 1'b1;
                mv_addr_next  = cursor_reg[AW-1:0] + AW'(1);
                if (cursor_reg == pos_ext) begin
                    state_next = ole_pkg::SEQ_INS_WRITE;
                end else begin
                    cursor_next = cursor_reg - 9'd1;
                end
            end

            // Last move drains first, then the new value lands at position
            ole_pkg::SEQ_INS_WRITE: begin
                if (!mv_valid_reg) begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[AW-1:0];
                    ram_wdata  = value_reg;
                    count_next = count_reg + 9'd1;
                    state_next = ole_pkg::SEQ_RESULT;
                end
            end

            // Walk up from the hole, moving each entry down a slot
            ole_pkg::SEQ_SHIFT_DOWN: begin
                if (cursor_reg < count_reg) begin
                    ram_raddr     = cursor_reg[AW-1:0];
                    mv_valid_next = 1'b1;
                    mv_addr_next  = cursor_reg[AW-1:0] - AW'(1);
                    cursor_next   = cursor_reg + 9'd1;
                end else begin
                    count_next = count_reg - 9'd1;
                    state_next = ole_pkg::SEQ_RESULT;
                end
            end

            // One read per cycle, each compared in the next cycle
            ole_pkg::SEQ_SEARCH: begin
                if (cmp_valid_reg && ole_pkg::ieee_equal(ram_rdata, value_reg)) begin
                    res_found_next = cmp_tag_reg;
                    if (func_reg == ole_pkg::FUNC_FIND) begin
                        state_next = ole_pkg::SEQ_RESULT;
                    end else begin
                        cursor_next = {1'b0, cmp_tag_reg} + 9'd1;
                        state_next  = ole_pkg::SEQ_SHIFT_DOWN;
                    end
                end else if (cursor_reg < count_reg) begin
                    ram_raddr      = cursor_reg[AW-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_tag_next   = cursor_reg[7:0];
                    cursor_next    = cursor_reg + 9'd1;
                end else if (!cmp_valid_reg) begin
                    res_status_next = ole_pkg::STATUS_NOT_FOUND;
                    state_next      = ole_pkg::SEQ_RESULT;
                end
            end

            ole_pkg::SEQ_READ_WAIT: begin
                res_rdata_next = ram_rdata;
                state_next     = ole_pkg::SEQ_RESULT;
            end

            ole_pkg::SEQ_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ole_pkg::SEQ_IDLE;
                end
            end

            default: begin
                state_next = ole_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign res.status         = res_status_reg;
    assign res.found_position = res_found_reg;
    assign res.read_data      = res_rdata_reg;
    assign res.count          = count_reg;
    assign res.empty_res      = (count_reg == 9'd0);

endmodule

>>> hw/rtl/ole_out_stage.sv
`timescale 1ns / 1ps

// Result register: frees the sequencer while the receiver stalls
module ole_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    output logic             res_ready,
    input  ole_pkg::result_t res,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_found_position,
    output logic [31:0]      m_read_data,
    output logic [8:0]       m_count,
    output logic             m_empty_res
);

    logic             valid_reg;
    ole_pkg::result_t data_reg;

    assign res_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid          = valid_reg;
    assign m_status         = data_reg.status;
    assign m_found_position = data_reg.found_position;
    assign m_read_data      = data_reg.read_data;
    assign m_count          = data_reg.count;
    assign m_empty_res      = data_reg.empty_res;

endmodule

>>> hw/rtl/ordered_list_engine.sv
// Ordered list of up to min(CAPACITY, 256) single-precision words.
// Command channel s_*: func, position and value, one operation per transfer.
// Result channel m_*: one transfer per command with status, found_position,
// read_data, and the count and empty flag after the operation.
// Commands run one at a time; s_ready is high only while the sequencer idles.
// How each command runs (n = count before the command, p = position):
//   append, write, clear, insert at p = n, and any rejected command: done in dispatch
//   read: dispatch issues the RAM read, the data is captured in the read-wait state
//   insert at p < n: entries n-1 down to p move up a slot (one RAM read and move per cycle)
//   remove at p: entries p+1 up to n-1 move down a slot
//   find: scan from index 0 until the first match or the end of the list
//   remove value: the find scan, then the remove walk from the match when found
// The walks take one entry at a time because the entry RAM has a single read port.
// The result sits in an output register, so a stalled m_ready holds only that
// register; the next command is taken and runs until its result needs it.
// Reset (aresetn low, synchronous) empties the list; entry contents are not
// cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [7:0]  s_position,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_found_position,
    output logic [31:0] m_read_data,
    output logic [8:0]  m_count,
    output logic        m_empty_res
);

    localparam int LIMIT = (CAPACITY < ole_pkg::STORE_DEPTH) ? CAPACITY
                                                              : ole_pkg::STORE_DEPTH;
    localparam int AW = $clog2(LIMIT);

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [31:0]      ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [31:0]      ram_rdata;
    logic             res_valid;
    logic             res_ready;
    ole_pkg::result_t res;

    // Entry store
    ole_ram #(
        .WIDTH (32),
        .DEPTH (LIMIT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Operation sequencer
    ole_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_position (s_position),
        .s_value    (s_value),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Result register
    ole_out_stage u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_read_data      (m_read_data),
        .m_count          (m_count),
        .m_empty_res      (m_empty_res)
    );

    // Checks
    `ASSERT_IMPLY(a_full_at_limit, m_valid && (m_status == ole_pkg::STATUS_FULL), m_count == 9'(LIMIT), "full status below capacity")
    `ASSERT_IMPLY(a_empty_flag, m_valid, m_empty_res == (m_count == 9'd0), "empty flag disagrees with count")
    `ASSERT_IMPLY(a_notfound_pos, m_valid && (m_status == ole_pkg::STATUS_NOT_FOUND), m_found_position == 8'd0, "not found with nonzero position")
    `ASSERT_IMPLY_NEXT(a_busy_after_cmd, s_valid && s_ready, !s_ready, "command taken while busy")

endmodule

>>> tb/sv/ordered_list_engine_tb.sv
`timescale 1ns / 1ps

module ordered_list_engine_tb;
    import ole_pkg::*;

    localparam int LIST_CAP    = 256;
    localparam int LIST_LIMIT  = (LIST_CAP < STORE_DEPTH) ? LIST_CAP : STORE_DEPTH;
    localparam int RAND_ITEMS  = 1600;
    // longest quiet stretch: a search over a full list plus the longest gaps
    localparam int STALL_LIMIT = 4000;
    localparam int NO_MATCH    = -1;

    // bit patterns that sit on the edges of IEEE equality
    localparam logic [31:0] ODD_FLOATS [10] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
        32'hFFC0_0001, 32'h7F80_0001, 32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF
    };

    typedef struct {
        func_t       op;
        logic [7:0]  pos;
        logic [31:0] val;
        bit          typed;
        result_t     res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = FUNC_CLEAR;
    logic [7:0]  s_position = 8'd0;
    logic [31:0] s_value = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_found_position;
    logic [31:0] m_read_data;
    logic [8:0]  m_count;
    logic        m_empty_res;

    // shadow copy of the list
    logic [31:0] shadow_mem [STORE_DEPTH];
    int          shadow_len = 0;

    result_t     pending_res [$];
    int          mism = 0;
    int          res_idx = 0;
    bit          calm = 1'b0;
    int          rdy_left = 0;

    // directed rows; typed results are the obvious ones, the rest use the predictor
    dir_row_t dir_tab [25] = '{
        '{FUNC_READ,       8'd0,   32'h0000_0000, 1'b1, '{STATUS_BAD_INDEX, 8'd0, 32'd0, 9'd0, 1'b1}},
        '{FUNC_REMOVE_AT,  8'd0,   32'h0000_0000, 1'b1, '{STATUS_BAD_INDEX, 8'd0, 32'd0, 9'd0, 1'b1}},
        '{FUNC_FIND,       8'd0,   32'h0000_0000, 1'b1, '{STATUS_NOT_FOUND, 8'd0, 32'd0, 9'd0, 1'b1}},
        '{FUNC_REMOVE_VAL, 8'd0,   32'h8000_0000, 1'b1, '{STATUS_NOT_FOUND, 8'd0, 32'd0, 9'd0, 1'b1}},
        '{FUNC_WRITE,      8'd0,   32'hFFFF_FFFF, 1'b1, '{STATUS_BAD_INDEX, 8'd0, 32'd0, 9'd0, 1'b1}},
        '{FUNC_INSERT,     8'd1,   32'h1234_5678, 1'b1, '{STATUS_BAD_INDEX, 8'd0, 32'd0, 9'd0, 1'b1}},
        '{FUNC_INSERT,     8'd0,   32'h8000_0000, 1'b1, '{STATUS_OK,        8'd0, 32'd0, 9'd1, 1'b0}},
        '{FUNC_APPEND,     8'd0,   32'h7FC0_0000, 1'b1, '{STATUS_OK,        8'd0, 32'd0, 9'd2, 1'b0}},
        '{FUNC_APPEND,     8'd255, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK,        8'd0, 32'd0, 9'd3, 1'b0}},
        '{FUNC_APPEND,     8'd0,   32'h7F80_0000, 1'b1, '{STATUS_OK,        8'd0, 32'd0, 9'd4, 1'b0}},
        '{FUNC_FIND,       8'd0,   32'h0000_0000, 1'b1, '{STATUS_OK,        8'd0, 32'd0, 9'd4, 1'b0}},
        '{FUNC_FIND,       8'd0,   32'h7FC0_0000, 1'b1, '{STATUS_NOT_FOUND, 8'd0, 32'd0, 9'd4, 1'b0}},
        '{FUNC_FIND,       8'd0,   32'hFF80_0000, 1'b1, '{STATUS_NOT_FOUND, 8'd0, 32'd0, 9'd4, 1'b0}},
        '{FUNC_FIND,       8'd0,   32'h7F80_0000, 1'b1, '{STATUS_OK,        8'd3, 32'd0, 9'd4, 1'b0}},
        '{FUNC_INSERT,     8'd4,   32'h3F80_0000, 1'b1, '{STATUS_OK,        8'd0, 32'd0, 9'd5, 1'b0}},
        '{FUNC_INSERT,     8'd0,   32'h0000_0001, 1'b0, '0},
        '{FUNC_READ,       8'd5,   32'h0000_0000, 1'b0, '0},
        '{FUNC_READ,       8'd6,   32'h0000_0000, 1'b1, '{STATUS_BAD_INDEX, 8'd0, 32'd0, 9'd6, 1'b0}},
        '{FUNC_WRITE,      8'd255, 32'h0000_0000, 1'b1, '{STATUS_BAD_INDEX, 8'd0, 32'd0, 9'd6, 1'b0}},
        '{FUNC_WRITE,      8'd2,   32'hDEAD_BEEF, 1'b0, '0},
        '{FUNC_REMOVE_AT,  8'd0,   32'h0000_0000, 1'b0, '0},
        '{FUNC_REMOVE_VAL, 8'd0,   32'h0000_0000, 1'b0, '0},
        '{FUNC_REMOVE_VAL, 8'd0,   32'hFFFF_FFFF, 1'b1, '{STATUS_NOT_FOUND, 8'd0, 32'd0, 9'd4, 1'b0}},
        '{FUNC_CLEAR,      8'd0,   32'h0000_0000, 1'b1, '{STATUS_OK,        8'd0, 32'd0, 9'd0, 1'b1}},
        '{FUNC_INSERT,     8'd255, 32'h1234_5678, 1'b1, '{STATUS_BAD_INDEX, 8'd0, 32'd0, 9'd0, 1'b1}}
    };

    ordered_list_engine #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_position(m_found_position),
        .m_read_data     (m_read_data),
        .m_count         (m_count),
        .m_empty_res     (m_empty_res)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // IEEE compare: NaN matches nothing, the two zeros match each other
    function automatic bit floats_match(input logic [31:0] a, input logic [31:0] b);
        bit a_nan;
        bit b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (a_nan || b_nan)
            return 1'b0;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return 1'b1;
        return a == b;
    endfunction

    function automatic int locate(input logic [31:0] val);
        int i;
        for (i = 0; i < shadow_len; i++)
            if (floats_match(shadow_mem[i], val))
                return i;
        return NO_MATCH;
    endfunction

    function automatic void drop_entry(input int idx);
        int i;
        for (i = idx; i + 1 < shadow_len; i++)
            shadow_mem[i] = shadow_mem[i + 1];
        shadow_len--;
    endfunction

    // applies one command to the shadow list and returns its result
    function automatic result_t apply_list_op(input func_t op, input logic [7:0] pos,
                                              input logic [31:0] val);
        result_t r;
        int      hit;
        int      i;
        r = '0;
        r.status = STATUS_OK;
        case (op)
            FUNC_APPEND: begin
                if (shadow_len >= LIST_LIMIT) begin
                    r.status = STATUS_FULL;
                end else begin
                    shadow_mem[shadow_len] = val;
                    shadow_len++;
                end
            end
            FUNC_INSERT: begin
                if (int'(pos) > shadow_len) begin
                    r.status = STATUS_BAD_INDEX;
                end else if (shadow_len >= LIST_LIMIT) begin
                    r.status = STATUS_FULL;
                end else begin
                    for (i = shadow_len; i > int'(pos); i--)
                        shadow_mem[i] = shadow_mem[i - 1];
                    shadow_mem[pos] = val;
                    shadow_len++;
                end
            end
            FUNC_REMOVE_AT: begin
                if (int'(pos) >= shadow_len)
                    r.status = STATUS_BAD_INDEX;
                else
                    drop_entry(int'(pos));
            end
            FUNC_REMOVE_VAL, FUNC_FIND: begin
                hit = locate(val);
                if (hit == NO_MATCH) begin
                    r.status = STATUS_NOT_FOUND;
                end else begin
                    r.found_position = hit[7:0];
                    if (op == FUNC_REMOVE_VAL)
                        drop_entry(hit);
                end
            end
            FUNC_READ: begin
                if (int'(pos) >= shadow_len)
                    r.status = STATUS_BAD_INDEX;
                else
                    r.read_data = shadow_mem[pos];
            end
            FUNC_WRITE: begin
                if (int'(pos) >= shadow_len)
                    r.status = STATUS_BAD_INDEX;
                else
                    shadow_mem[pos] = val;
            end
            default: begin
                shadow_len = 0;
            end
        endcase
        r.count     = shadow_len[8:0];
        r.empty_res = (shadow_len == 0);
        return r;
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // values: stored ones for hits, IEEE edge patterns, or plain random
    function automatic logic [31:0] pick_value();
        int          r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 35 && shadow_len > 0) begin
            v = shadow_mem[$urandom_range(0, shadow_len - 1)];
            if (v[30:0] == 31'd0 && $urandom_range(0, 1) == 1)
                v[31] = ~v[31];
        end else if (r < 50) begin
            v = ODD_FLOATS[$urandom_range(0, 9)];
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    // one command transfer; called on a clock edge, returns on the accepting edge
    task automatic send_cmd(input func_t op, input logic [7:0] pos, input logic [31:0] val,
                            input bit typed, input result_t typed_res);
        int      gap;
        result_t r;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= op;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        r = apply_list_op(op, pos, val);
        pending_res.push_back(typed ? typed_res : r);
    endtask

    // sender holds off until every outstanding result is back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_res.size() > 0);
    endtask

    // result-side backpressure
    always @(posedge aclk) begin : rdy_gen
        int g;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rdy_left <= 0;
        end else if (calm) begin
            m_ready  <= 1'b1;
        end else if (rdy_left > 0) begin
            rdy_left <= rdy_left - 1;
        end else begin
            g = pick_gap();
            if (m_ready && g > 0) begin
                m_ready  <= 1'b0;
                rdy_left <= g - 1;
            end else begin
                m_ready  <= 1'b1;
                rdy_left <= $urandom_range(0, 7);
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_chk
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                mism++;
                if (mism <= 10)
                    $display("result %0d with nothing pending: status=%0d found=%0d data=%h count=%0d empty=%0d",
                             res_idx, m_status, m_found_position, m_read_data, m_count, m_empty_res);
            end else begin
                want = pending_res.pop_front();
                if (m_status !== want.status || m_found_position !== want.found_position ||
                    m_read_data !== want.read_data || m_count !== want.count ||
                    m_empty_res !== want.empty_res) begin
                    mism++;
                    if (mism <= 10)
                        $display("result %0d mismatch: expected status=%0d found=%0d data=%h count=%0d empty=%0d, got status=%0d found=%0d data=%h count=%0d empty=%0d",
                                 res_idx, want.status, want.found_position, want.read_data,
                                 want.count, want.empty_res, m_status, m_found_position,
                                 m_read_data, m_count, m_empty_res);
                end
            end
            res_idx++;
        end
    end

    // ends the run when no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ordered_list_engine_tb: FAIL");
        $finish;
    end

    initial begin : stim
        int          n;
        int          r;
        int          tgt_len;
        bit          over;
        func_t       op;
        logic [7:0]  p;
        logic [31:0] v;
        tgt_len = 8;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (n = 0; n < 25; n++)
            send_cmd(dir_tab[n].op, dir_tab[n].pos, dir_tab[n].val,
                     dir_tab[n].typed, dir_tab[n].res);
        hold_until_drained();

        // fill to capacity, then exercise the full list and the top index
        send_cmd(FUNC_CLEAR, 8'd0, 32'd0, 1'b0, '0);
        for (n = 0; n < LIST_LIMIT; n++)
            send_cmd(FUNC_APPEND, 8'($urandom), $urandom, 1'b0, '0);
        send_cmd(FUNC_APPEND, 8'd0, $urandom, 1'b0, '0);
        send_cmd(FUNC_INSERT, 8'd0, $urandom, 1'b0, '0);
        send_cmd(FUNC_INSERT, 8'd255, $urandom, 1'b0, '0);
        send_cmd(FUNC_READ, 8'd255, 32'd0, 1'b0, '0);
        send_cmd(FUNC_WRITE, 8'd255, 32'h8000_0000, 1'b0, '0);
        send_cmd(FUNC_FIND, 8'd0, 32'h0000_0000, 1'b0, '0);
        send_cmd(FUNC_FIND, 8'd0, 32'h7FC0_0000, 1'b0, '0);
        send_cmd(FUNC_REMOVE_AT, 8'd255, 32'd0, 1'b0, '0);
        send_cmd(FUNC_REMOVE_AT, 8'd0, 32'd0, 1'b0, '0);
        send_cmd(FUNC_INSERT, 8'd0, 32'hFFFF_FFFF, 1'b0, '0);
        send_cmd(FUNC_APPEND, 8'd0, 32'h0000_0000, 1'b0, '0);
        send_cmd(FUNC_REMOVE_VAL, 8'd0, shadow_mem[200], 1'b0, '0);
        send_cmd(FUNC_CLEAR, 8'd0, 32'd0, 1'b0, '0);
        hold_until_drained();

        // random commands, list length steered toward a per-stretch target
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 150 == 0) begin
                calm    <= ($urandom_range(0, 3) == 0);
                tgt_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(2, 16);
            end
            if ($urandom_range(0, 199) == 0)
                hold_until_drained();
            over = shadow_len >= tgt_len;
            r    = $urandom_range(0, 99);
            if (over) begin
                if (r < 40)      op = FUNC_REMOVE_AT;
                else if (r < 70) op = FUNC_REMOVE_VAL;
                else if (r < 75) op = FUNC_CLEAR;
                else if (r < 85) op = FUNC_FIND;
                else if (r < 95) op = FUNC_READ;
                else             op = FUNC_WRITE;
            end else begin
                if (r < 22)      op = FUNC_APPEND;
                else if (r < 40) op = FUNC_INSERT;
                else if (r < 50) op = FUNC_REMOVE_AT;
                else if (r < 58) op = FUNC_REMOVE_VAL;
                else if (r < 72) op = FUNC_FIND;
                else if (r < 84) op = FUNC_READ;
                else if (r < 96) op = FUNC_WRITE;
                else             op = FUNC_CLEAR;
            end
            if (shadow_len == 0 || $urandom_range(0, 9) == 0)
                p = 8'($urandom_range(0, 255));
            else if (op == FUNC_INSERT)
                p = 8'($urandom_range(0, shadow_len));
            else
                p = 8'($urandom_range(0, shadow_len - 1));
            v = pick_value();
            send_cmd(op, p, v, 1'b0, '0);
        end

        hold_until_drained();
        repeat (20) @(posedge aclk);
        if (mism == 0)
            $display("ordered_list_engine_tb: PASS");
        else
            $display("ordered_list_engine_tb: FAIL");
        $finish;
    end

endmodule
